FILE: rtl/ura_pkg.sv
// Shared types and constants for the ultrasonic range averager.
package ura_pkg;

  localparam int unsigned Samples      = 8;
  localparam int unsigned SampleBits   = 4;
  localparam int unsigned TickBits     = 24;
  localparam int unsigned CmBits       = 19;
  localparam int unsigned FracBits     = 10;
  localparam int unsigned SumBits      = 22;
  localparam int unsigned TimerBits    = 8;
  localparam int unsigned CfgIdxBits   = 1;
  localparam int unsigned CfgDataBits  = 8;
  localparam int unsigned InDataBits   = 8;
  localparam int unsigned OutDataBits  = 32;

  localparam logic [FracBits-1:0] CmPerTick  = FracBits'(17);
  localparam logic [FracBits:0]   TicksPerCm = (FracBits + 1)'(1000);

  localparam logic [TimerBits-1:0] TriggerReset = TimerBits'(20);
  localparam logic [TimerBits-1:0] SettleReset  = TimerBits'(10);

  localparam logic [CfgIdxBits-1:0] RegTriggerTicks = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] RegSettleTicks  = CfgIdxBits'(1);

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhTrig   = 3'd1,
    PhSettle = 3'd2,
    PhWait   = 3'd3,
    PhMeas   = 3'd4
  } phase_e;

  typedef struct packed {
    logic               trigger;
    logic               busy_res;
    logic               done_res;
    logic [SumBits-1:0] distance_eighths;
  } result_t;

endpackage

FILE: rtl/ultrasonic_range_averager.sv
// Ultrasonic ranger controller that averages eight echo measurements.
//
// The input stream carries one word per 1 us tick: tdata[0] is start_req and
// tdata[1] is the echo pin level. Every accepted input word yields exactly one
// output word: tdata[0] trigger, [1] busy_res, [2] done_res, [24:3]
// distance_eighths, and the upper bits are zero.
// A start request in idle runs eight trigger, settle, wait and measure cycles.
// The echo width is converted to centimeters incrementally while it is counted,
// so a tick is handled in a single pass with no multiplier.
// The output word is registered and is valid in the cycle after input acceptance,
// and one input word is accepted per cycle while the output side keeps up.
// A single output register separates the two sides: input is accepted when the
// output register is empty or is being drained in the same cycle.
// When the receiver stalls, the held output word stays stable and the input
// side stalls with it, so no tick is lost.
// Reset clears the phase, counters, sum and output valid, and restores the
// trigger length to 20 ticks and the settle time to 10 ticks.
// Configuration registers are written through cfg_we_i, cfg_idx_i, cfg_data_i
// and take effect on the next tick.
module ultrasonic_range_averager (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ura_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [ura_pkg::CfgDataBits-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: start_req, echo, zero fill.
  input  logic [ura_pkg::InDataBits-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0: trigger, busy_res, done_res, distance_eighths, zero fill.
  output logic [ura_pkg::OutDataBits-1:0]  m_axis_tdata
);

  localparam int unsigned TickBits   = ura_pkg::TickBits;
  localparam int unsigned CmBits     = ura_pkg::CmBits;
  localparam int unsigned FracBits   = ura_pkg::FracBits;
  localparam int unsigned SumBits    = ura_pkg::SumBits;
  localparam int unsigned TimerBits  = ura_pkg::TimerBits;
  localparam int unsigned SampleBits = ura_pkg::SampleBits;

  logic [TimerBits-1:0]  trig_ticks_q, settle_ticks_q;
  ura_pkg::phase_e       phase_q, phase_d;
  logic [TimerBits-1:0]  timer_q, timer_d;
  logic [TickBits-1:0]   ticks_q, ticks_d;
  logic [CmBits-1:0]     cm_q, cm_d;
  logic [FracBits-1:0]   frac_q, frac_d;
  logic [SampleBits-1:0] idx_q, idx_d;
  logic [SumBits-1:0]    sum_q, sum_d;
  logic                  out_valid_q;
  ura_pkg::result_t      res_q, res_d;

  logic                  accept;
  logic                  start_req, echo;
  ura_pkg::phase_e       cur_phase;
  logic [TimerBits-1:0]  cur_timer;
  logic [SampleBits-1:0] cur_idx;
  logic [SumBits-1:0]    cur_sum;
  logic [FracBits:0]     frac_inc;
  logic [SumBits:0]      sum_add;
  logic [SampleBits-1:0] idx_inc;

  assign start_req     = s_axis_tdata[0];
  assign echo          = s_axis_tdata[1];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ura_pkg::OutDataBits - SumBits - 3){1'b0}},
                          res_q.distance_eighths, res_q.done_res,
                          res_q.busy_res, res_q.trigger};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_ticks_q   <= ura_pkg::TriggerReset;
      settle_ticks_q <= ura_pkg::SettleReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ura_pkg::RegTriggerTicks: trig_ticks_q   <= cfg_data_i;
        ura_pkg::RegSettleTicks:  settle_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ura_pkg::PhIdle;
      timer_q     <= '0;
      ticks_q     <= '0;
      cm_q        <= '0;
      frac_q      <= '0;
      idx_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        timer_q     <= timer_d;
        ticks_q     <= ticks_d;
        cm_q        <= cm_d;
        frac_q      <= frac_d;
        idx_q       <= idx_d;
        sum_q       <= sum_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    cur_phase = phase_q;
    cur_timer = timer_q;
    cur_idx   = idx_q;
    cur_sum   = sum_q;
    if (phase_q == ura_pkg::PhIdle && start_req) begin
      cur_phase = ura_pkg::PhTrig;
      cur_timer = '0;
      cur_idx   = '0;
      cur_sum   = '0;
    end

    phase_d  = cur_phase;
    timer_d  = cur_timer;
    ticks_d  = ticks_q;
    cm_d     = cm_q;
    frac_d   = frac_q;
    idx_d    = cur_idx;
    sum_d    = cur_sum;
    res_d    = '0;
    frac_inc = {1'b0, frac_q} + {1'b0, ura_pkg::CmPerTick};
    sum_add  = {1'b0, cur_sum} + {{(SumBits + 1 - CmBits){1'b0}}, cm_q};
    idx_inc  = cur_idx + SampleBits'(1);

    case (cur_phase)
      ura_pkg::PhIdle: ;
      ura_pkg::PhTrig: begin
        res_d.trigger = 1'b1;
        if ({1'b0, cur_timer} + (TimerBits + 1)'(1) >= {1'b0, trig_ticks_q}) begin
          timer_d = '0;
          phase_d = (settle_ticks_q == '0) ? ura_pkg::PhWait : ura_pkg::PhSettle;
        end else begin
          timer_d = cur_timer + TimerBits'(1);
        end
      end
      ura_pkg::PhSettle: begin
        if ({1'b0, cur_timer} + (TimerBits + 1)'(1) >= {1'b0, settle_ticks_q}) begin
          timer_d = '0;
          phase_d = ura_pkg::PhWait;
        end else begin
          timer_d = cur_timer + TimerBits'(1);
        end
      end
      ura_pkg::PhWait: begin
        if (echo) begin
          ticks_d = TickBits'(1);
          cm_d    = '0;
          frac_d  = ura_pkg::CmPerTick;
          phase_d = ura_pkg::PhMeas;
        end
      end
      ura_pkg::PhMeas: begin
        if (echo) begin
          if (ticks_q != {TickBits{1'b1}}) begin
            ticks_d = ticks_q + TickBits'(1);
            if (frac_inc >= ura_pkg::TicksPerCm) begin
              frac_d = FracBits'(frac_inc - ura_pkg::TicksPerCm);
              cm_d   = cm_q + CmBits'(1);
            end else begin
              frac_d = frac_inc[FracBits-1:0];
            end
          end
        end else begin
          sum_d   = sum_add[SumBits] ? {SumBits{1'b1}} : sum_add[SumBits-1:0];
          ticks_d = '0;
          idx_d   = idx_inc;
          if ({28'd0, idx_inc} >= 32'(ura_pkg::Samples)) begin
            res_d.done_res         = 1'b1;
            res_d.distance_eighths = sum_d;
            phase_d                = ura_pkg::PhIdle;
          end else begin
            timer_d = '0;
            phase_d = ura_pkg::PhTrig;
          end
        end
      end
      default: phase_d = ura_pkg::PhIdle;
    endcase

    res_d.busy_res = (phase_d != ura_pkg::PhIdle);
  end

endmodule
